>>> rtl/ksg_pkg.sv
package ksg_pkg;

	// Largest number of set elements held in the element memory
	localparam int MAX_SET = 16;

	// Fixed field widths
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 4;
	localparam int CFG_W  = 5;
	localparam int REQ_W  = 2;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD    = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_NEXT    = 2'd2
	} req_type_t;

	// Register indexes, taken from address bit 2
	localparam logic REG_SET_SIZE = 1'b0;
	localparam logic REG_CHOOSE_K = 1'b1;

	// Register reset values
	localparam logic [CFG_W-1:0] SET_SIZE_RST = 5'd16;
	localparam logic [CFG_W-1:0] CHOOSE_K_RST = 5'd1;

	// Status from the mask search unit
	typedef struct packed {
		logic done;
		logic found;
	} srch_status_t;

endpackage

>>> rtl/ksg_in_if.sv
interface ksg_in_if import ksg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [IDX_W-1:0]        load_index;
	logic signed [VAL_W-1:0] load_value;

	modport source (output valid, output req_type, output load_index, output load_value,
		input ready);
	modport sink (input valid, input req_type, input load_index, input load_value,
		output ready);
endinterface

>>> rtl/ksg_out_if.sv
interface ksg_out_if import ksg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_value;
	logic [IDX_W-1:0]        out_index;
	logic                    has_element;
	logic                    last;
	logic                    exhausted;

	modport source (output valid, output out_value, output out_index, output has_element,
		output last, output exhausted, input ready);
	modport sink (input valid, input out_value, input out_index, input has_element,
		input last, input exhausted, output ready);
endinterface

>>> rtl/ksg_elem_mem.sv
module ksg_elem_mem import ksg_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ksg_mask_search.sv
// Bit-serial search for the smallest mask at or above the start mask with
// exactly k ones inside the low n bits. Walks bit positions from n-1 down to 0,
// one per cycle, keeping the candidate of the lowest position that fits.
module ksg_mask_search import ksg_pkg::*; #(
	parameter int MW = 17,
	parameter int PW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MW-1:0]    mask,
	input  logic [CFG_W-1:0] k,
	input  logic [PW-1:0]    n,
	output srch_status_t     status,
	output logic [MW-1:0]    result
);

	localparam int CW = ((PW > CFG_W) ? PW : CFG_W) + 1;

	logic [MW-1:0] mask_q;
	logic [CW-1:0] k_q;
	logic [PW-1:0] cnt_q;
	logic [CW-1:0] hi_q;
	logic [MW-1:0] cand_q;
	logic          cand_vld_q;
	logic          over_q;
	logic          busy_q;
	logic          done_q;
	logic          found_q;
	logic [MW-1:0] result_q;

	logic [PW-1:0] pos;
	logic [CW-1:0] have;
	logic          fits;
	logic [MW-1:0] cand;
	logic          over;

	function automatic logic [MW-1:0] low_ones(input logic [CW-1:0] w);
		logic [MW-1:0] r;
		for (int j = 0; j < MW; j++) begin
			r[j] = (CW'(j) < w);
		end
		return r;
	endfunction

	// Candidate at the current position: keep bits above, set this bit, fill the bottom
	always_comb begin
		pos  = cnt_q - PW'(1);
		have = hi_q + CW'(1);
		fits = !mask_q[pos] && (have <= k_q) && ((k_q - have) <= CW'(pos));
		cand = (mask_q & ~low_ones(CW'(pos) + CW'(1))) | (MW'(1) << pos) |
			low_ones(k_q - have);
		over = |(mask & ~low_ones(CW'(n)));
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mask_q     <= mask;
			k_q        <= CW'(k);
			cnt_q      <= n;
			hi_q       <= '0;
			cand_vld_q <= 1'b0;
			over_q     <= over;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (fits) begin
					cand_q     <= cand;
					cand_vld_q <= 1'b1;
				end
				hi_q  <= hi_q + CW'(mask_q[pos]);
				cnt_q <= pos;
			end else begin
				// Start mask itself wins when it already has k ones
				found_q  <= !over_q && ((hi_q == k_q) || cand_vld_q);
				result_q <= (hi_q == k_q) ? mask_q : cand_q;
			end
		end
	end

	assign status.done  = done_q;
	assign status.found = found_q;
	assign result       = result_q;

endmodule

>>> rtl/k_subset_generator_top.sv
// k-subset generator. Load elements into positions 0..MAX_SET-1 (req_type 0), restart
// the enumeration (req_type 1), then each next request (req_type 2) returns the next
// k-element subset of the first set_size elements as a run of transactions in index
// order, the final one marked last; k = 0 gives one empty transaction, and a request
// with nothing left (or k above the set size, or no restart yet) gives one exhausted
// transaction. Loads and restarts complete in the idle state. A next request first runs
// the mask search, which walks one bit position of the n-bit mask per cycle
// (n = effective set size), then reads each element through the single read port of
// the element memory into the output register; exhausted and empty results skip the
// element reads. The element memory is not cleared and must be loaded before use.
module k_subset_generator_top import ksg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ksg_in_if.sink            req,
	ksg_out_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int MW = MAX_SET + 1;
	localparam int PW = $clog2(MW);
	localparam int IW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PUT,
		ST_RD,
		ST_DATA
	} st_t;

	st_t state_q;

	logic [CFG_W-1:0] set_size_q;
	logic [CFG_W-1:0] choose_k_q;
	logic [MW-1:0]    scan_mask_q;
	logic             active_q;
	logic [MW-1:0]    emit_q;
	logic [PW-1:0]    rd_idx_q;
	logic             rd_last_q;
	logic             put_exh_q;

	logic                    ov_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [IDX_W-1:0]        out_index_q;
	logic                    has_element_q;
	logic                    last_q;
	logic                    exhausted_q;

	logic             accept;
	logic             out_free;
	logic [PW-1:0]    n_eff;
	logic             k_over;
	logic [MW-1:0]    restart_mask;
	logic [PW-1:0]    low_idx;
	logic             emit_last;
	logic             mem_we;
	logic             mem_re;
	logic [VAL_W-1:0] mem_rdata;
	logic             srch_start;
	srch_status_t     srch_st;
	logic [MW-1:0]    srch_x;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= SET_SIZE_RST;
			choose_k_q <= CHOOSE_K_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_SET_SIZE: set_size_q <= pwdata[CFG_W-1:0];
				REG_CHOOSE_K: choose_k_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHOOSE_K) ? APB_DW'(choose_k_q) : APB_DW'(set_size_q);

	// Request decode and helpers
	always_comb begin
		accept   = req.valid && req.ready;
		out_free = !ov_q || rsp.ready;
		n_eff    = (int'(set_size_q) > MAX_SET) ? PW'(MAX_SET) : PW'(set_size_q);
		k_over   = int'(choose_k_q) > int'(n_eff);
		for (int j = 0; j < MW; j++) begin
			restart_mask[j] = (j < int'(choose_k_q));
		end
		// Lowest remaining chosen position
		low_idx = '0;
		for (int j = MW - 1; j >= 0; j--) begin
			if (emit_q[j]) begin
				low_idx = PW'(j);
			end
		end
		emit_last  = (emit_q & (emit_q - MW'(1))) == '0;
		mem_we     = accept && (req.req_type == REQ_LOAD) && (int'(req.load_index) < MAX_SET);
		mem_re     = (state_q == ST_RD) && out_free;
		srch_start = accept && (req.req_type == REQ_NEXT) && active_q && !k_over;
	end

	assign req.ready = (state_q == ST_IDLE);

	ksg_elem_mem #(
		.DEPTH(MAX_SET),
		.AW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(IW'(req.load_index)),
		.wdata(req.load_value),
		.re   (mem_re),
		.raddr(IW'(low_idx)),
		.rdata(mem_rdata)
	);

	ksg_mask_search #(
		.MW(MW),
		.PW(PW)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (srch_start),
		.mask  (scan_mask_q),
		.k     (choose_k_q),
		.n     (n_eff),
		.status(srch_st),
		.result(srch_x)
	);

	// Control sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_mask_q   <= '0;
			active_q      <= 1'b0;
			emit_q        <= '0;
			rd_idx_q      <= '0;
			rd_last_q     <= 1'b0;
			put_exh_q     <= 1'b0;
			ov_q          <= 1'b0;
			out_value_q   <= '0;
			out_index_q   <= '0;
			has_element_q <= 1'b0;
			last_q        <= 1'b0;
			exhausted_q   <= 1'b0;
		end else begin
			// Drop a taken transaction unless a new one loads this cycle
			if (ov_q && rsp.ready && state_q != ST_PUT && state_q != ST_DATA) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						case (req.req_type)
							REQ_RESTART: begin
								scan_mask_q <= restart_mask;
								active_q    <= 1'b1;
							end
							REQ_NEXT: begin
								if (!active_q || k_over) begin
									active_q  <= 1'b0;
									put_exh_q <= 1'b1;
									state_q   <= ST_PUT;
								end else begin
									state_q <= ST_SEARCH;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SEARCH: begin
					if (srch_st.done) begin
						if (!srch_st.found) begin
							active_q  <= 1'b0;
							put_exh_q <= 1'b1;
							state_q   <= ST_PUT;
						end else begin
							scan_mask_q <= srch_x + MW'(1);
							if (srch_x == '0) begin
								put_exh_q <= 1'b0;
								state_q   <= ST_PUT;
							end else begin
								emit_q  <= srch_x;
								state_q <= ST_RD;
							end
						end
					end
				end
				ST_PUT: begin
					if (out_free) begin
						ov_q          <= 1'b1;
						out_value_q   <= '0;
						out_index_q   <= '0;
						has_element_q <= 1'b0;
						last_q        <= 1'b1;
						exhausted_q   <= put_exh_q;
						state_q       <= ST_IDLE;
					end
				end
				ST_RD: begin
					// Issue the read only when the output slot is free next cycle
					if (out_free) begin
						rd_idx_q  <= low_idx;
						rd_last_q <= emit_last;
						emit_q    <= emit_q & ~(MW'(1) << low_idx);
						state_q   <= ST_DATA;
					end
				end
				ST_DATA: begin
					ov_q          <= 1'b1;
					out_value_q   <= mem_rdata;
					out_index_q   <= IDX_W'(rd_idx_q);
					has_element_q <= 1'b1;
					last_q        <= rd_last_q;
					exhausted_q   <= 1'b0;
					state_q       <= rd_last_q ? ST_IDLE : ST_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.out_value   = out_value_q;
	assign rsp.out_index   = out_index_q;
	assign rsp.has_element = has_element_q;
	assign rsp.last        = last_q;
	assign rsp.exhausted   = exhausted_q;

	// A found mask carries exactly k ones
	a_found_popcount: assert property (@(posedge clk) disable iff (!arst_n)
		srch_st.done && srch_st.found |-> $countones(srch_x) == int'(choose_k_q))
		else $error("search result popcount differs from k");

	// Read data is only consumed the cycle after a read was issued
	a_data_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DATA |-> $past(mem_re))
		else $error("element taken without a preceding read");

	// Output slot is free whenever read data lands
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> !ov_q)
		else $error("output register busy when read data arrives");

endmodule

>>> test/ksg_checker.sv
module ksg_checker import ksg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ksg_in_if                 req_mon,
	ksg_out_if                rsp_mon,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                errors,
	output int                pending,
	output int                requests_seen,
	output int                results_seen,
	output int                runs_seen,
	output int                empty_seen,
	output int                exhausted_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_MAX    = 16;
	localparam int MASK_W     = SET_MAX + 1;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic                    has_elem;
		logic                    last;
		logic                    exhausted;
	} subset_beat_t;

	// Shadow of the block state
	logic signed [VAL_W-1:0] elem_store [SET_MAX];
	bit [63:0]               scan_mask;
	bit                      scan_active;
	int                      cfg_set_size;
	int                      cfg_k;

	subset_beat_t subset_beats_q [$];

	int err_count     = 0;
	int req_count     = 0;
	int result_count  = 0;
	int run_count     = 0;
	int empty_count   = 0;
	int exhaust_count = 0;

	function automatic bit [63:0] ones_mask(input int w);
		if (w >= 64) begin
			return '1;
		end
		return (64'd1 << w) - 64'd1;
	endfunction

	// Smallest mask at or above from_mask with exactly k ones, setting no new bit above top_bit
	function automatic bit find_next_subset_mask(input bit [63:0] from_mask, input int k,
		input int top_bit, output bit [63:0] found);
		bit [63:0] cand;
		int        have;
		found = '0;
		if ($countones(from_mask) == k) begin
			found = from_mask;
			return 1'b1;
		end
		for (int i = 0; i <= top_bit && i < 63; i++) begin
			if (!from_mask[i]) begin
				cand = (from_mask & ~ones_mask(i + 1)) | (64'd1 << i);
				have = $countones(cand);
				if (have <= k && k - have <= i) begin
					found = cand | ones_mask(k - have);
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic push_beat(input logic signed [VAL_W-1:0] value, input int index,
		input logic has_elem, input logic last, input logic exhausted);
		subset_beat_t beat;
		beat.value     = value;
		beat.index     = IDX_W'(index);
		beat.has_elem  = has_elem;
		beat.last      = last;
		beat.exhausted = exhausted;
		subset_beats_q = {subset_beats_q, beat};
	endtask

	task automatic give_up_scan();
		scan_active = 1'b0;
		exhaust_count++;
		push_beat('0, 0, 1'b0, 1'b1, 1'b1);
	endtask

	// Update shadow state for one accepted request and queue the results it causes
	task automatic predict_request(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
		input logic signed [VAL_W-1:0] val);
		int        n;
		int        k;
		int        taken;
		bit [63:0] hit;
		bit [63:0] top_mask;
		case (req_type_t'(kind))
			REQ_LOAD: begin
				elem_store[idx] = val;
			end
			REQ_RESTART: begin
				scan_mask   = ones_mask(cfg_k) & ones_mask(MASK_W);
				scan_active = 1'b1;
			end
			REQ_NEXT: begin
				n = (cfg_set_size > SET_MAX) ? SET_MAX : cfg_set_size;
				k = cfg_k;
				if (!scan_active || k > n) begin
					give_up_scan();
				end else begin
					top_mask = ones_mask(k) << (n - k);
					if (!find_next_subset_mask(scan_mask, k, n, hit) || hit > top_mask) begin
						give_up_scan();
					end else begin
						scan_mask = (hit + 64'd1) & ones_mask(MASK_W);
						if (k == 0) begin
							empty_count++;
							push_beat('0, 0, 1'b0, 1'b1, 1'b0);
						end else begin
							// emit chosen elements in index order
							run_count++;
							taken = 0;
							for (int i = 0; i < n; i++) begin
								if (hit[i]) begin
									push_beat(elem_store[i], i, 1'b1, (taken + 1 == k), 1'b0);
									taken++;
								end
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		err_count++;
		$display("[%0t] result %0d: %s got %0d, expected %0d", $time, result_count, what,
			got, want);
	endtask

	task automatic check_result();
		subset_beat_t want;
		result_count++;
		if (subset_beats_q.size() == 0) begin
			flag_mismatch("unexpected transaction, index", rsp_mon.out_index, -1);
			return;
		end
		want = subset_beats_q.pop_front();
		if (rsp_mon.out_value !== want.value)
			flag_mismatch("out_value", rsp_mon.out_value, want.value);
		if (rsp_mon.out_index !== want.index)
			flag_mismatch("out_index", rsp_mon.out_index, want.index);
		if (rsp_mon.has_element !== want.has_elem)
			flag_mismatch("has_element", rsp_mon.has_element, want.has_elem);
		if (rsp_mon.last !== want.last)
			flag_mismatch("last", rsp_mon.last, want.last);
		if (rsp_mon.exhausted !== want.exhausted)
			flag_mismatch("exhausted", rsp_mon.exhausted, want.exhausted);
	endtask

	// Sample all channels on the rising edge, publish counts for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_set_size = int'(SET_SIZE_RST);
			cfg_k        = int'(CHOOSE_K_RST);
			scan_mask    = '0;
			scan_active  = 1'b0;
			subset_beats_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_CHOOSE_K)
					cfg_k = int'(pwdata[CFG_W-1:0]);
				else
					cfg_set_size = int'(pwdata[CFG_W-1:0]);
			end
			if (req_mon.valid && req_mon.ready) begin
				req_count++;
				predict_request(req_mon.req_type, req_mon.load_index, req_mon.load_value);
			end
			if (rsp_mon.valid && rsp_mon.ready)
				check_result();
		end
		errors         <= err_count;
		pending        <= subset_beats_q.size();
		requests_seen  <= req_count;
		results_seen   <= result_count;
		runs_seen      <= run_count;
		empty_seen     <= empty_count;
		exhausted_seen <= exhaust_count;
	end

endmodule

>>> test/tb_k_subset_generator_top.sv
module tb_k_subset_generator_top import ksg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              LIMIT_CYCLES  = 400_000;
	localparam int              SETTLE_CYCLES = 64;
	localparam int              HOLD_CYCLES   = 500;
	localparam int              TOTAL_ITEMS   = 350;
	localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;

	typedef enum {RX_FREE, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int errors;
	int pending;
	int requests_seen;
	int results_seen;
	int runs_seen;
	int empty_seen;
	int exhausted_seen;

	bit [15:0] loaded        = '0;
	int        items_sent    = 0;
	int        burst_left    = 1;
	int        phases        = 0;
	int        cycles        = 0;
	bit        long_hold_go  = 1'b0;

	ksg_in_if  req_if ();
	ksg_out_if rsp_if ();

	k_subset_generator_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ksg_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_mon        (req_if),
		.rsp_mon        (rsp_if),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.errors         (errors),
		.pending        (pending),
		.requests_seen  (requests_seen),
		.results_seen   (results_seen),
		.runs_seen      (runs_seen),
		.empty_seen     (empty_seen),
		.exhausted_seen (exhausted_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
		$display("Simulation FAILED");
		$finish;
	end

	// Result receiver: stall on shifting random patterns, plus one long hold-off
	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		int       hold_left;
		rx_mode   = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_go) begin
				long_hold_go = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (rx_mode)
					RX_FREE:   rsp_if.ready <= 1'b1;
					RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: rsp_if.ready <= ($urandom_range(0, 9) != 0);
					default:   rsp_if.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Offer one transaction, hold it until accepted, then maybe open a gap
	task automatic send_item(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
		input logic [VAL_W-1:0] val);
		int gap;
		req_if.valid      <= 1'b1;
		req_if.req_type   <= kind;
		req_if.load_index <= idx;
		req_if.load_value <= val;
		do @(posedge clk); while (!req_if.ready);
		items_sent++;
		if (kind == REQ_LOAD)
			loaded[idx] = 1'b1;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Non-load request with junk in the load fields
	task automatic send_op(input logic [REQ_W-1:0] kind);
		send_item(kind, IDX_W'($urandom), $urandom);
	endtask

	task automatic write_reg(input logic reg_sel, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, 5'(value)};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid and wait until every expected result is out and the block is quiet
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One configuration phase: mostly next requests on a fresh or continued scan
	task automatic run_phase(input int size_cfg, input int k_cfg, input int count,
		input bit do_restart, input bit long_hold);
		int roll;
		int span;
		phases++;
		write_reg(REG_SET_SIZE, size_cfg);
		write_reg(REG_CHOOSE_K, k_cfg);
		span = (size_cfg > 16) ? 16 : size_cfg;
		// load every element the scan may read
		for (int i = 0; i < span; i++) begin
			if (!loaded[i])
				send_item(REQ_LOAD, IDX_W'(i), $urandom);
		end
		if (do_restart)
			send_op(REQ_RESTART);
		if (long_hold)
			long_hold_go = 1'b1;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 78)
				send_op(REQ_NEXT);
			else if (roll < 88)
				send_item(REQ_LOAD, IDX_W'($urandom), $urandom);
			else if (roll < 94)
				send_op(REQ_RESTART);
			else
				send_op(REQ_UNUSED);
		end
		settle();
	endtask

	initial begin
		int n;
		int k;
		int roll;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		req_if.valid      <= 1'b0;
		req_if.req_type   <= REQ_LOAD;
		req_if.load_index <= '0;
		req_if.load_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: next before any restart, unknown request, value extremes
		write_reg(REG_SET_SIZE, 3);
		write_reg(REG_CHOOSE_K, 2);
		send_op(REQ_NEXT);
		send_op(REQ_UNUSED);
		send_item(REQ_LOAD, 4'd0, 32'h8000_0000);
		send_item(REQ_LOAD, 4'd1, 32'h7fff_ffff);
		send_item(REQ_LOAD, 4'd2, 32'hffff_ffff);
		send_item(REQ_LOAD, 4'd15, 32'h0000_0000);
		// every 2-of-3 subset, then exhaustion
		send_op(REQ_RESTART);
		repeat (4) send_op(REQ_NEXT);
		settle();
		// empty subset, then nothing left
		write_reg(REG_CHOOSE_K, 0);
		send_op(REQ_RESTART);
		repeat (2) send_op(REQ_NEXT);
		settle();
		// k above the set size
		write_reg(REG_CHOOSE_K, 4);
		send_op(REQ_RESTART);
		send_op(REQ_NEXT);
		settle();
		// empty set
		write_reg(REG_SET_SIZE, 0);
		write_reg(REG_CHOOSE_K, 0);
		send_op(REQ_RESTART);
		repeat (2) send_op(REQ_NEXT);
		settle();
		phases = 4;

		// Register extremes, then the long receiver hold-off on a big scan
		run_phase(16, 16, 6, 1'b1, 1'b0);
		run_phase(31, 1, 20, 1'b1, 1'b0);
		run_phase(17, 15, 12, 1'b1, 1'b0);
		run_phase(1, 1, 4, 1'b1, 1'b0);
		run_phase(16, 0, 4, 1'b1, 1'b0);
		run_phase(5, 31, 4, 1'b1, 1'b0);
		run_phase(16, 8, 40, 1'b1, 1'b1);

		// Random phases, mostly small sets so scans run out
		while (items_sent < TOTAL_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				n = $urandom_range(2, 6);
				k = $urandom_range(0, n);
			end else if (roll < 85) begin
				n = $urandom_range(7, 16);
				k = $urandom_range(1, n);
			end else begin
				n = $urandom_range(0, 31);
				k = $urandom_range(0, 31);
			end
			run_phase(n, k, $urandom_range(8, 30), ($urandom_range(0, 99) < 85), 1'b0);
		end

		$display("Covered %0d requests and %0d checked results in %0d configuration phases",
			requests_seen, results_seen, phases);
		$display("Subset runs %0d, empty subsets %0d, exhausted replies %0d, mismatches %0d",
			runs_seen, empty_seen, exhausted_seen, errors);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
